// ----- hdl/lru_k_frame_replacer_assert.svh -----
// Assertion macros for the LRU-K frame replacer.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef LRU_K_FRAME_REPLACER_ASSERT_SVH
`define LRU_K_FRAME_REPLACER_ASSERT_SVH
`ifndef SYNTHESIS
`define LRUK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LRUK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) \
		else $error(msg);
`else
`define LRUK_ASSERT(label, prop, msg)
`define LRUK_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- hdl/lruk_pkg.sv -----
`default_nettype none

package lruk_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int FRAME_W    = 6;
	localparam int FCNT_W     = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [1:0] {
		REQ_RECORD      = 2'd0,
		REQ_SET_MARK    = 2'd1,
		REQ_FIND_VICTIM = 2'd2,
		REQ_REMOVE      = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		STAT_OK            = 2'd0,
		STAT_RANGE         = 2'd1,
		STAT_NO_VICTIM     = 2'd2,
		STAT_NOT_EVICTABLE = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HISTORY_DEPTH = 1'd0,
		CFG_FRAMES_IN_USE = 1'd1
	} cfg_idx_t;

	typedef struct packed {
		req_type_t          req_type;
		logic [FRAME_W-1:0] frame_num;
		logic               evictable_flag;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [FRAME_W-1:0] victim_frame;
		logic [FCNT_W-1:0]  evictable_count;
	} rsp_t;

	// control from the scan pipeline to the victim picker
	typedef struct packed {
		logic               clear;
		logic               cand_valid;
		logic               cand_inf;
		logic [FRAME_W-1:0] cand_id;
	} pick_ctl_t;

	typedef struct packed {
		logic               found;
		logic [FRAME_W-1:0] best_id;
	} pick_res_t;

endpackage

`default_nettype wire

// ----- hdl/lruk_sync_ram.sv -----
`default_nettype none

module lruk_sync_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/lruk_victim_pick.sv -----
`default_nettype none

module lruk_victim_pick
	import lruk_pkg::*;
#(
	parameter int STAMP_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pick_ctl_t              ctl,
	input  logic [STAMP_WIDTH-1:0] cand_ts,
	output pick_res_t              res
);

	logic                   found_q;
	logic                   best_inf_q;
	logic [STAMP_WIDTH-1:0] best_ts_q;
	logic [FRAME_W-1:0]     best_id_q;
	logic                   take;

	// infinite distance beats finite; within a class the older stamp wins,
	// and a tie keeps the earlier (lower) frame
	always_comb begin
		take = ctl.cand_valid && (!found_q || (ctl.cand_inf && !best_inf_q) ||
			(ctl.cand_inf == best_inf_q && cand_ts < best_ts_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_inf_q <= ctl.cand_inf;
			best_ts_q  <= cand_ts;
			best_id_q  <= ctl.cand_id;
		end
	end

	assign res.found   = found_q;
	assign res.best_id = best_id_q;

endmodule

`default_nettype wire

// ----- hdl/lru_k_frame_replacer.sv -----
// LRU-K frame replacer. Record, set-mark and remove pass through an operation state and
// then a finish state; an out-of-range frame goes straight to the finish state; find-victim
// scans frames_in_use frames, one metadata read per frame on the single read port, then
// finishes. A new request is taken only once the last one has left the finish state, and a
// stalled result holds the finish state. After reset a clearing pass writes all 64 metadata
// entries before the first request is taken; configuration writes are taken during the pass.
`default_nettype none
`include "lru_k_frame_replacer_assert.svh"

module lru_k_frame_replacer
	import lruk_pkg::*;
#(
	parameter int MAX_HISTORY = 4,
	parameter int STAMP_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// metadata entry: {mark, oldest slot, history length}
	localparam int LW        = $clog2(MAX_HISTORY + 1);
	localparam int SW        = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
	localparam int MW        = LW + SW + 1;
	localparam int SDEPTH    = MAX_FRAMES * (2 ** SW);
	localparam int SAW       = FRAME_W + SW;
	localparam int DEPTH_RST = (MAX_HISTORY < 2) ? MAX_HISTORY : 2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_OP,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t                 state_q;
	logic [FRAME_W-1:0]     clr_idx_q;
	req_t                   req_q;
	logic [LW-1:0]          depth_q;
	logic [FCNT_W-1:0]      frames_q;
	logic                   access_seen_q;
	logic [STAMP_WIDTH-1:0] access_clock_q;
	logic [FCNT_W-1:0]      evict_total_q;
	status_t                res_status_q;
	logic [FRAME_W-1:0]     res_victim_q;
	logic [FCNT_W-1:0]      issue_idx_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	// scan pipeline
	logic                   v_s1;
	logic [FRAME_W-1:0]     id_s1;
	logic                   v_s2;
	logic                   inf_s2;
	logic [FRAME_W-1:0]     id_s2;

	// memory ports
	logic                   meta_we;
	logic [FRAME_W-1:0]     meta_waddr;
	logic [MW-1:0]          meta_wdata;
	logic [FRAME_W-1:0]     meta_raddr;
	logic [MW-1:0]          meta_rdata;
	logic                   st_we;
	logic [SAW-1:0]         st_waddr;
	logic [STAMP_WIDTH-1:0] st_wdata;
	logic [SAW-1:0]         st_raddr;
	logic [STAMP_WIDTH-1:0] st_rdata;

	logic [LW-1:0]          rd_len;
	logic [SW-1:0]          rd_old;
	logic                   rd_mark;
	logic [LW-1:0]          new_len;
	logic [SW-1:0]          new_old;
	logic                   new_mark;
	logic [LW-1:0]          old_inc;
	status_t                op_status;
	logic                   total_inc;
	logic                   total_dec;
	logic                   clock_adv;

	logic                   req_take;
	logic                   out_free;
	logic                   issue_go;
	logic                   scan_done;
	logic                   record_op;
	int                     depth_new;
	int                     frames_new;

	pick_ctl_t              pick_ctl;
	pick_res_t              pick_res;

	assign rd_len  = meta_rdata[LW-1:0];
	assign rd_old  = meta_rdata[LW+SW-1:LW];
	assign rd_mark = meta_rdata[MW-1];

	// Handshake: take a request only when the engine is idle; the output register
	// may still hold the previous result.
	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Scan: issue one frame per cycle, then drain the two pipeline stages.
	assign issue_go  = (state_q == ST_SCAN) && (issue_idx_q < frames_q);
	assign scan_done = (state_q == ST_SCAN) && !issue_go && !v_s1 && !v_s2;

	always_comb begin
		case (state_q)
			ST_SCAN: meta_raddr = issue_idx_q[FRAME_W-1:0];
			default: meta_raddr = req.frame_num;
		endcase
	end

	// stamp read for the frame whose metadata just arrived
	assign st_raddr = {id_s1, rd_old};
	assign st_wdata = access_clock_q + STAMP_WIDTH'(1);

	// Clamp configuration values into their legal ranges.
	always_comb begin
		depth_new = int'(cfg_data[2:0]);
		if (depth_new < 1) begin
			depth_new = 1;
		end else if (depth_new > MAX_HISTORY) begin
			depth_new = MAX_HISTORY;
		end
		frames_new = int'(cfg_data);
		if (frames_new < 1) begin
			frames_new = 1;
		end else if (frames_new > MAX_FRAMES) begin
			frames_new = MAX_FRAMES;
		end
	end

	// Read-modify-write of one metadata entry. Before the depth is reached the
	// oldest slot stays zero, so the next free slot is the history length itself.
	always_comb begin
		meta_we    = 1'b0;
		meta_waddr = req_q.frame_num;
		meta_wdata = '0;
		new_len    = rd_len;
		new_old    = rd_old;
		new_mark   = rd_mark;
		old_inc    = LW'(rd_old) + LW'(1);
		st_we      = 1'b0;
		st_waddr   = {req_q.frame_num, rd_old};
		op_status  = STAT_OK;
		total_inc  = 1'b0;
		total_dec  = 1'b0;
		clock_adv  = 1'b0;
		if (state_q == ST_CLEAR) begin
			meta_we    = 1'b1;
			meta_waddr = clr_idx_q;
		end else if (state_q == ST_OP) begin
			meta_we = 1'b1;
			case (req_q.req_type)
				REQ_RECORD: begin
					clock_adv = 1'b1;
					st_we     = 1'b1;
					if (rd_len < depth_q) begin
						st_waddr = {req_q.frame_num, SW'(rd_len)};
						new_len  = rd_len + LW'(1);
					end else begin
						// full: overwrite the oldest stamp and advance the ring
						new_old = (old_inc == depth_q) ? '0 : SW'(old_inc);
					end
				end
				REQ_SET_MARK: begin
					if (rd_len != '0 && rd_mark != req_q.evictable_flag) begin
						new_mark  = req_q.evictable_flag;
						total_inc = req_q.evictable_flag;
						total_dec = !req_q.evictable_flag;
					end
				end
				REQ_REMOVE: begin
					if (rd_len != '0) begin
						if (!rd_mark) begin
							op_status = STAT_NOT_EVICTABLE;
						end else begin
							new_len   = '0;
							new_old   = '0;
							new_mark  = 1'b0;
							total_dec = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
			meta_wdata = {new_mark, new_old, new_len};
		end
	end

	// Control, configuration and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_idx_q      <= '0;
			req_q          <= '0;
			depth_q        <= LW'(DEPTH_RST);
			frames_q       <= FCNT_W'(MAX_FRAMES);
			access_seen_q  <= 1'b0;
			access_clock_q <= '0;
			evict_total_q  <= '0;
			res_status_q   <= STAT_OK;
			res_victim_q   <= '0;
			issue_idx_q    <= '0;
			rsp_valid_q    <= 1'b0;
			rsp_q          <= '0;
		end else begin
			// depth is frozen once the first access is recorded
			if (cfg_we) begin
				case (cfg_index)
					CFG_HISTORY_DEPTH: begin
						if (!access_seen_q) begin
							depth_q <= LW'(depth_new);
						end
					end
					CFG_FRAMES_IN_USE: frames_q <= FCNT_W'(frames_new);
					default: begin
					end
				endcase
			end

			// drop the result once the consumer takes it, unless a new one loads
			if (rsp_valid_q && !rsp_stall && state_q != ST_FINISH) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + FRAME_W'(1);
					if (clr_idx_q == FRAME_W'(MAX_FRAMES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_take) begin
						req_q       <= req;
						issue_idx_q <= '0;
						if (req.req_type == REQ_FIND_VICTIM) begin
							state_q <= ST_SCAN;
						end else if ({1'b0, req.frame_num} >= frames_q) begin
							res_status_q <= STAT_RANGE;
							res_victim_q <= '0;
							state_q      <= ST_FINISH;
						end else begin
							state_q <= ST_OP;
						end
					end
				end
				ST_OP: begin
					res_status_q <= op_status;
					res_victim_q <= '0;
					if (clock_adv) begin
						access_clock_q <= st_wdata;
						access_seen_q  <= 1'b1;
					end
					if (total_inc) begin
						evict_total_q <= evict_total_q + FCNT_W'(1);
					end else if (total_dec && evict_total_q != '0) begin
						evict_total_q <= evict_total_q - FCNT_W'(1);
					end
					state_q <= ST_FINISH;
				end
				ST_SCAN: begin
					if (issue_go) begin
						issue_idx_q <= issue_idx_q + FCNT_W'(1);
					end
					if (scan_done) begin
						res_status_q <= pick_res.found ? STAT_OK : STAT_NO_VICTIM;
						res_victim_q <= pick_res.found ? pick_res.best_id : '0;
						state_q      <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// hold the result until the output register is free
					if (out_free) begin
						rsp_q.status          <= res_status_q;
						rsp_q.victim_frame    <= res_victim_q;
						rsp_q.evictable_count <= evict_total_q;
						rsp_valid_q           <= 1'b1;
						state_q               <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Scan pipeline: metadata read, then stamp read, then compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue_go;
			v_s2 <= v_s1 && rd_mark && rd_len != '0;
		end
	end

	always_ff @(posedge clk) begin
		id_s1  <= issue_idx_q[FRAME_W-1:0];
		inf_s2 <= rd_len < depth_q;
		id_s2  <= id_s1;
	end

	assign pick_ctl.clear      = req_take && req.req_type == REQ_FIND_VICTIM;
	assign pick_ctl.cand_valid = v_s2;
	assign pick_ctl.cand_inf   = inf_s2;
	assign pick_ctl.cand_id    = id_s2;

	lruk_sync_ram #(
		.WIDTH(MW),
		.DEPTH(MAX_FRAMES)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(meta_waddr),
		.wdata(meta_wdata),
		.raddr(meta_raddr),
		.rdata(meta_rdata)
	);

	lruk_sync_ram #(
		.WIDTH(STAMP_WIDTH),
		.DEPTH(SDEPTH)
	) u_stamp_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	lruk_victim_pick #(
		.STAMP_WIDTH(STAMP_WIDTH)
	) u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pick_ctl),
		.cand_ts(st_rdata),
		.res    (pick_res)
	);

	assign record_op = (state_q == ST_OP) && (req_q.req_type == REQ_RECORD);

	`LRUK_ASSERT(a_total_bound, evict_total_q <= FCNT_W'(MAX_FRAMES), "evictable total overflow")
	`LRUK_ASSERT(a_cand_in_scan, v_s2 |-> state_q == ST_SCAN, "victim candidate outside scan")
	`LRUK_ASSERT(a_no_meta_wr_scan, meta_we |-> state_q != ST_SCAN, "metadata write during scan")
	`LRUK_ASSERT(a_clock_record, !$stable(access_clock_q) |-> $past(record_op), "stray clock step")
	`LRUK_ASSERT_NEXT(a_depth_frozen, access_seen_q, $stable(depth_q), "depth changed after access")

endmodule

`default_nettype wire
